### rtl/bse_pkg.sv
package bse_pkg;

    localparam int MAX_LENGTH_DEF = 256;
    localparam int NUM_BINS       = 256;
    localparam int BIN_AW         = 8;
    localparam int LG_FRAC        = 16;
    localparam int MANT_W         = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [15:0] THRESH_RESET = 16'd18432;
    localparam logic [15:0] ENTROPY_MAX  = 16'd32768;

    typedef struct packed {
        logic       bump;
        logic       close;
        logic [7:0] byte_value;
    } t_cmd_ctl;

endpackage

### rtl/bse_if.sv
interface bse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       carries_byte;
    logic       last_byte;

    modport source (output valid, output byte_value, output carries_byte, output last_byte,
                    input ready);
    modport sink (input valid, input byte_value, input carries_byte, input last_byte,
                  output ready);
endinterface

interface bse_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] entropy_bits;
    logic        below_threshold;
    logic [8:0]  byte_total;

    modport source (output valid, output entropy_bits, output below_threshold,
                    output byte_total, input ready);
    modport sink (input valid, input entropy_bits, input below_threshold,
                  input byte_total, output ready);
endinterface

interface bse_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] low_entropy_threshold;

    modport source (output valid, output low_entropy_threshold, input ready);
    modport sink (input valid, input low_entropy_threshold, output ready);
endinterface

### rtl/bse_ram.sv
module bse_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bse_fifo.sv
module bse_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/bse_front.sv
module bse_front import bse_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    localparam int LEN_W     = $clog2(MAX_LENGTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bse_in_if.sink           i_in,
    input  logic             i_hold,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd_ctl         o_cmd,
    output logic [LEN_W-1:0] o_len
);

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LENGTH);

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             accept;
    logic             counted;

    assign i_in.ready = !i_full && !i_hold;
    assign accept     = i_in.valid && i_in.ready;
    assign counted    = i_in.carries_byte && (r_len < LEN_LIMIT);

    always_comb begin
        n_len = r_len;
        if (accept) begin
            if (i_in.last_byte) begin
                n_len = '0;
            end else if (counted) begin
                n_len = r_len + LEN_W'(1);
            end
        end
    end

    assign o_push = accept && (counted || i_in.last_byte);
    assign o_cmd  = '{bump: counted, close: i_in.last_byte, byte_value: i_in.byte_value};
    assign o_len  = counted ? r_len + LEN_W'(1) : r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_LIMIT)
        else $error("Set length ran past its limit.");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("Command pushed into a full queue.");

endmodule

### rtl/bse_log2.sv
module bse_log2 import bse_pkg::*; #(
    parameter int XW  = 9,
    localparam int KW = $clog2(XW + 1),
    localparam int OW = KW + LG_FRAC,
    localparam int CW = $clog2(LG_FRAC)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [XW-1:0] i_x,
    output logic          o_done,
    output logic [OW-1:0] o_lg
);

    localparam int SQ_W = 2 * MANT_W;

    logic [KW-1:0]      k;
    logic [MANT_W-1:0]  m0;
    logic [SQ_W-1:0]    sq;
    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [MANT_W-1:0]  r_m;
    logic [KW-1:0]      r_k;
    logic [LG_FRAC-1:0] r_frac;

    always_comb begin
        k = '0;
        for (int b = 0; b < XW; b++) begin
            if (i_x[b]) begin
                k = KW'(b);
            end
        end
        m0 = MANT_W'(i_x) << (MANT_W - 1 - int'(k));
    end

    assign sq = SQ_W'(r_m) * SQ_W'(r_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(LG_FRAC - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_m   <= m0;
            r_k   <= k;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_m    <= sq[SQ_W-1] ? sq[SQ_W-1 -: MANT_W] : sq[SQ_W-2 -: MANT_W];
            r_frac <= {r_frac[LG_FRAC-2:0], sq[SQ_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_lg   = {r_k, r_frac};

endmodule

### rtl/bse_div.sv
module bse_div #(
    parameter int DW  = 26,
    parameter int VW  = 9,
    localparam int CW = $clog2(DW)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_d;
    logic [DW-1:0] r_q;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_q[DW-1]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_d   <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= fits ? VW'(trial - {1'b0, r_d}) : VW'(trial);
            r_q   <= {r_q[DW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### rtl/bse_back.sv
module bse_back import bse_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    localparam int LEN_W     = $clog2(MAX_LENGTH + 1),
    localparam int KW        = $clog2(LEN_W + 1),
    localparam int LGW       = KW + LG_FRAC,
    localparam int PW        = LEN_W + LGW,
    localparam int DW        = (PW - 3 > 17) ? PW - 3 : 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_cmd_ctl         i_cmd,
    input  logic [LEN_W-1:0] i_len,
    output logic             o_pop,
    output logic             o_hold,
    bse_cfg_if.sink          i_cfg,
    bse_out_if.source        o_out
);

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_RUN  = 11'b000_0000_0010,
        S_RD   = 11'b000_0000_0100,
        S_CHK  = 11'b000_0000_1000,
        S_LOG  = 11'b000_0001_0000,
        S_ACC  = 11'b000_0010_0000,
        S_NLOG = 11'b000_0100_0000,
        S_NUM  = 11'b000_1000_0000,
        S_DIV0 = 11'b001_0000_0000,
        S_DIV  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    localparam logic [BIN_AW-1:0] IDX_LAST = BIN_AW'(NUM_BINS - 1);

    t_state            r_state;
    t_state            n_state;
    logic [BIN_AW-1:0] r_idx;
    logic              r_s1_valid;
    logic [BIN_AW-1:0] r_s1_addr;
    logic              r_lw_valid;
    logic [BIN_AW-1:0] r_lw_addr;
    logic [LEN_W-1:0]  r_lw_data;
    logic              r_bump_done;
    logic [LEN_W-1:0]  r_n;
    logic [LEN_W-1:0]  r_c;
    logic [PW-1:0]     r_prod;
    logic [PW-1:0]     r_acc;
    logic [15:0]       r_h;
    logic [15:0]       r_thr;
    logic              r_out_valid;
    logic [15:0]       r_out_h;
    logic              r_out_below;
    logic [8:0]        r_out_total;

    logic              head_bump;
    logic              issue;
    logic              close_go;
    logic              idx_last;
    logic              out_load;
    logic [LEN_W-1:0]  s1_base;
    logic [LEN_W-1:0]  s1_wdata;
    logic              ram_we;
    logic [BIN_AW-1:0] ram_waddr;
    logic [LEN_W-1:0]  ram_wdata;
    logic [BIN_AW-1:0] ram_raddr;
    logic [LEN_W-1:0]  ram_rdata;
    logic              log_start;
    logic [LEN_W-1:0]  log_x;
    logic              log_done;
    logic [LGW-1:0]    log_lg;
    logic              div_start;
    logic [PW:0]       dsum;
    logic [DW-1:0]     div_dvd;
    logic              div_done;
    logic [DW-1:0]     div_q;

    assign head_bump = !i_empty && i_cmd.bump && !r_bump_done;
    assign issue     = (r_state == S_RUN) && head_bump;
    assign close_go  = (r_state == S_RUN) && !i_empty && !head_bump && i_cmd.close
                       && !r_s1_valid;
    assign o_pop     = (issue && !i_cmd.close) || close_go;
    assign o_hold    = (r_state == S_CLR);
    assign idx_last  = (r_idx == IDX_LAST);

    // A read misses only the write made in its own cycle, so one stage of bypass is enough.
    assign s1_base  = (r_lw_valid && r_lw_addr == r_s1_addr) ? r_lw_data : ram_rdata;
    assign s1_wdata = s1_base + LEN_W'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        if (r_s1_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_s1_addr;
            ram_wdata = s1_wdata;
        end else if (r_state == S_CLR || r_state == S_CHK) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = issue ? i_cmd.byte_value : r_idx;

    bse_ram #(
        .W     (LEN_W),
        .DEPTH (NUM_BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        log_start = 1'b0;
        log_x     = r_n;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_CLR: begin
                if (idx_last) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (close_go) begin
                    n_state = (i_len == '0) ? S_OUT : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (ram_rdata > LEN_W'(1)) begin
                    log_start = 1'b1;
                    log_x     = ram_rdata;
                    n_state   = S_LOG;
                end else if (idx_last) begin
                    log_start = 1'b1;
                    n_state   = S_NLOG;
                end else begin
                    n_state = S_RD;
                end
            end
            S_LOG: begin
                if (log_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (idx_last) begin
                    log_start = 1'b1;
                    n_state   = S_NLOG;
                end else begin
                    n_state = S_RD;
                end
            end
            S_NLOG: begin
                if (log_done) begin
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                n_state = S_DIV0;
            end
            S_DIV0: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    bse_log2 #(
        .XW (LEN_W)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_lg    (log_lg)
    );

    // The quotient is rounded half up by adding 8 * r_n, half the full divisor 16 * r_n, before the shift by four.
    assign dsum    = {1'b0, r_acc} + ((PW + 1)'(r_n) << 3);
    assign div_dvd = DW'(dsum[PW:4]);

    bse_div #(
        .DW (DW),
        .VW (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_s1_valid  <= 1'b0;
            r_lw_valid  <= 1'b0;
            r_bump_done <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= THRESH_RESET;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= issue;
            r_lw_valid <= r_s1_valid;
            if (i_cfg.valid) begin
                r_thr <= i_cfg.low_entropy_threshold;
            end
            if (issue && i_cmd.close) begin
                r_bump_done <= 1'b1;
            end else if (close_go) begin
                r_bump_done <= 1'b0;
            end
            if (r_state == S_CLR || (r_state == S_CHK && n_state == S_RD)
                || (r_state == S_ACC && !idx_last)) begin
                r_idx <= r_idx + 1'b1;
            end else if (close_go) begin
                r_idx <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_cmd.byte_value;
        r_lw_addr <= r_s1_addr;
        r_lw_data <= s1_wdata;
        if (close_go) begin
            r_n   <= i_len;
            r_acc <= '0;
            r_h   <= '0;
        end
        if (r_state == S_CHK) begin
            r_c <= ram_rdata;
        end
        if (r_state == S_LOG && log_done) begin
            r_prod <= PW'(r_c) * PW'(log_lg);
        end
        if (r_state == S_NLOG && log_done) begin
            r_prod <= PW'(r_n) * PW'(log_lg);
        end
        if (r_state == S_ACC) begin
            r_acc <= r_acc + r_prod;
        end
        if (r_state == S_NUM) begin
            r_acc <= (r_prod > r_acc) ? r_prod - r_acc : '0;
        end
        if (r_state == S_DIV && div_done) begin
            r_h <= (div_q > DW'(ENTROPY_MAX)) ? ENTROPY_MAX : div_q[15:0];
        end
        if (out_load) begin
            r_out_h     <= r_h;
            r_out_below <= (r_h < r_thr);
            r_out_total <= 9'(r_n);
        end
    end

    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.entropy_bits    = r_out_h;
    assign o_out.below_threshold = r_out_below;
    assign o_out.byte_total      = r_out_total;

    a_bump_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> r_state == S_RUN)
        else $error("Histogram update overlaps a sweep write.");

    a_flag_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_below == (r_out_h < r_thr))
        else $error("Low-entropy flag disagrees with the held result.");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_h <= ENTROPY_MAX)
        else $error("Entropy result above the saturation limit.");

endmodule

### rtl/byte_shannon_entropy.sv
// Channel   Dir  Beat fields
// i_in      in   byte_value[7:0], carries_byte, last_byte
// o_out     out  entropy_bits[15:0], below_threshold, byte_total[8:0]
// i_cfg     in   low_entropy_threshold[15:0]
//
// After reset a clearing pass zeroes all 256 bins before the first input beat is taken.
// Histogram updates run back to back through a bypassed RAM port. Closing a nonempty set
// sweeps all bins: a read and a check per bin, plus a log (16-step log unit) and an accumulate
// for counts above one; then a log of the length, and a divide of one quotient bit per cycle.
// A four-entry command queue lets input run ahead while results wait on the output register.
module byte_shannon_entropy import bse_pkg::*; #(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bse_in_if.sink    i_in,
    bse_out_if.source o_out,
    bse_cfg_if.sink   i_cfg
);

    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam int Q_W   = $bits(t_cmd_ctl) + LEN_W;

    logic             push;
    t_cmd_ctl         push_cmd;
    logic [LEN_W-1:0] push_len;
    logic             q_full;
    logic             q_empty;
    logic             pop;
    logic [Q_W-1:0]   q_head;
    t_cmd_ctl         head_cmd;
    logic [LEN_W-1:0] head_len;
    logic             hold;

    assign {head_cmd, head_len} = q_head;

    bse_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_hold  (hold),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .o_len   (push_len)
    );

    bse_fifo #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_cmd, push_len}),
        .i_pop   (pop),
        .o_data  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bse_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (head_cmd),
        .i_len   (head_len),
        .o_pop   (pop),
        .o_hold  (hold),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb import bse_pkg::*; ();

    typedef struct packed {
        logic [7:0] byte_value;
        logic       carries_byte;
        logic       last_byte;
    } t_byte_beat;

    typedef struct packed {
        logic [15:0] entropy_bits;
        logic        below_threshold;
        logic [8:0]  byte_total;
    } t_entropy_result;

    logic clk;
    logic rst_n;

    bse_in_if  byte_bus ();
    bse_out_if result_bus ();
    bse_cfg_if thresh_bus ();

    byte_shannon_entropy dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_bus),
        .o_out   (result_bus),
        .i_cfg   (thresh_bus)
    );

    t_byte_beat      beat_queue[$];
    t_entropy_result expected_entropy[$];
    t_byte_beat      staged_beat;
    t_entropy_result want;

    int unsigned bin_count[NUM_BINS];
    int unsigned set_len;
    logic [15:0] threshold_cfg;

    int  beats_queued;
    int  beats_taken;
    bit  beat_taken;
    int  mismatches;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_left;
    bit  long_hold_req;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #40ms;
        $display("FAIL");
        $finish;
    end

    function automatic longint unsigned log2_q16(input int unsigned x);
        int unsigned      k;
        int unsigned      t;
        longint unsigned  m;
        longint unsigned  frac;
        k = 0;
        frac = 0;
        if (x == 0) return 0;
        t = x;
        while (t > 1) begin
            t = t >> 1;
            k++;
        end
        m = longint'(x) << (31 - k);
        for (int i = LG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        return (longint'(k) << LG_FRAC) | frac;
    endfunction

    function automatic logic [15:0] set_entropy();
        longint unsigned n;
        longint unsigned s;
        longint unsigned whole;
        longint unsigned num;
        longint unsigned h;
        n = set_len;
        if (n == 0) return 16'd0;
        s = 0;
        for (int i = 0; i < NUM_BINS; i++) begin
            if (bin_count[i] != 0)
                s += longint'(bin_count[i]) * log2_q16(bin_count[i]);
        end
        whole = n * log2_q16(set_len);
        num = (whole > s) ? whole - s : 0;
        h = (num + 8 * n) / (16 * n);
        if (h > ENTROPY_MAX) h = ENTROPY_MAX;
        return h[15:0];
    endfunction

    task automatic absorb_beat(input t_byte_beat b);
        t_entropy_result r;
        if (b.carries_byte && set_len < MAX_LENGTH_DEF) begin
            bin_count[b.byte_value]++;
            set_len++;
        end
        if (b.last_byte) begin
            r.entropy_bits    = set_entropy();
            r.below_threshold = (r.entropy_bits < threshold_cfg);
            r.byte_total      = set_len[8:0];
            expected_entropy  = {expected_entropy, r};
            for (int i = 0; i < NUM_BINS; i++) bin_count[i] = 0;
            set_len = 0;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && byte_bus.valid && byte_bus.ready) begin
            beat_taken = 1'b1;
            beats_taken++;
            absorb_beat('{byte_bus.byte_value, byte_bus.carries_byte, byte_bus.last_byte});
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            byte_bus.valid <= 1'b0;
        end else if (!byte_bus.valid || beat_taken) begin
            beat_taken = 1'b0;
            if (beat_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                staged_beat = beat_queue.pop_front();
                byte_bus.valid        <= 1'b1;
                byte_bus.byte_value   <= staged_beat.byte_value;
                byte_bus.carries_byte <= staged_beat.carries_byte;
                byte_bus.last_byte    <= staged_beat.last_byte;
            end else begin
                byte_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            result_bus.ready <= 1'b0;
            hold_left--;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 10000;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && result_bus.valid && result_bus.ready) begin
            if (expected_entropy.size() == 0) begin
                $display("%0t: unexpected result entropy %0d flag %0d total %0d", $time,
                         result_bus.entropy_bits, result_bus.below_threshold,
                         result_bus.byte_total);
                mismatches++;
            end else begin
                want = expected_entropy.pop_front();
                if (result_bus.entropy_bits !== want.entropy_bits) begin
                    $display("%0t: entropy_bits expected %0d actual %0d", $time,
                             want.entropy_bits, result_bus.entropy_bits);
                    mismatches++;
                end
                if (result_bus.below_threshold !== want.below_threshold) begin
                    $display("%0t: below_threshold expected %0d actual %0d", $time,
                             want.below_threshold, result_bus.below_threshold);
                    mismatches++;
                end
                if (result_bus.byte_total !== want.byte_total) begin
                    $display("%0t: byte_total expected %0d actual %0d", $time,
                             want.byte_total, result_bus.byte_total);
                    mismatches++;
                end
            end
        end
    end

    task automatic queue_beat(input logic [7:0] value, input logic has, input logic last);
        t_byte_beat b;
        b = '{value, has, last};
        beat_queue = {beat_queue, b};
        beats_queued++;
    endtask

    task automatic queue_set(input int len, input int alphabet, input bit split_close);
        logic [7:0] base;
        logic [7:0] value;
        base = 8'($urandom);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(15) == 0) queue_beat(8'($urandom), 1'b0, 1'b0);
            value = base + 8'($urandom_range(alphabet - 1));
            queue_beat(value, 1'b1, (i == len - 1) && !split_close);
        end
        if (split_close || len == 0) queue_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic queue_spread_set();
        logic [7:0] order[NUM_BINS];
        logic [7:0] swap;
        int         j;
        for (int i = 0; i < NUM_BINS; i++) order[i] = 8'(i);
        for (int i = NUM_BINS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (int i = 0; i < NUM_BINS; i++) queue_beat(order[i], 1'b1, i == NUM_BINS - 1);
    endtask

    task automatic queue_random_sets(input int budget);
        int used;
        int len;
        int pick;
        int alphabet;
        bit split_close;
        used = 0;
        while (used < budget) begin
            pick = $urandom_range(99);
            if (pick < 4) len = 0;
            else if (pick < 60) len = $urandom_range(1, 16);
            else if (pick < 82) len = $urandom_range(17, 96);
            else if (pick < 95) len = $urandom_range(97, 256);
            else len = $urandom_range(257, 320);
            pick = $urandom_range(2);
            if (pick == 0) alphabet = $urandom_range(1, 4);
            else if (pick == 1) alphabet = $urandom_range(5, 32);
            else alphabet = NUM_BINS;
            split_close = (len == 0) || ($urandom_range(99) < 30);
            queue_set(len, alphabet, split_close);
            used += len + split_close;
        end
    endtask

    task automatic wait_idle(input int settle);
        while (beats_taken != beats_queued || expected_entropy.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        @(negedge clk);
        thresh_bus.valid                 <= 1'b1;
        thresh_bus.low_entropy_threshold <= value;
        do @(posedge clk); while (!thresh_bus.ready);
        threshold_cfg = value;
        @(negedge clk);
        thresh_bus.valid <= 1'b0;
    endtask

    initial begin
        rst_n = 1'b0;
        byte_bus.valid = 1'b0;
        byte_bus.byte_value = 8'd0;
        byte_bus.carries_byte = 1'b0;
        byte_bus.last_byte = 1'b0;
        thresh_bus.valid = 1'b0;
        thresh_bus.low_entropy_threshold = 16'd0;
        result_bus.ready = 1'b0;
        for (int i = 0; i < NUM_BINS; i++) bin_count[i] = 0;
        set_len = 0;
        threshold_cfg = THRESH_RESET;
        beats_queued = 0;
        beats_taken = 0;
        beat_taken = 1'b0;
        mismatches = 0;
        hold_left = 0;
        long_hold_req = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 62;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_beat(8'hA5, 1'b0, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b1);
        queue_beat(8'h00, 1'b1, 1'b1);
        queue_beat(8'hFF, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b1);
        queue_beat(8'h55, 1'b1, 1'b0);
        queue_beat(8'hAA, 1'b1, 1'b0);
        queue_beat(8'h0F, 1'b1, 1'b0);
        queue_beat(8'hF0, 1'b1, 1'b0);
        queue_beat(8'h3C, 1'b0, 1'b1);
        for (int i = 0; i < 8; i++) queue_beat(8'h01 << i, 1'b1, i == 7);
        queue_beat(8'hFF, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b0, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b1);
        wait_idle(600);

        write_threshold(16'd0);
        queue_spread_set();
        queue_set(300, NUM_BINS, 1'b0);
        queue_set(256, 1, 1'b0);
        queue_random_sets(80);
        wait_idle(600);

        send_idle_pct = 62;
        recv_idle_pct = 37;
        write_threshold(16'hFFFF);
        queue_random_sets(80);
        wait_idle(600);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(16'd32768);
        queue_spread_set();
        queue_random_sets(40);
        wait_idle(600);

        write_threshold(16'($urandom_range(4096, 28672)));
        long_hold_req = 1'b1;
        for (int i = 0; i < 30; i++) queue_set($urandom_range(1, 6), 4, 1'($urandom_range(1)));
        queue_random_sets(50);
        wait_idle(600);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
